### rtl/core/quad_shape_preservation_matrix_assert.svh
// Assertion macros for the quad shape-preservation matrix block.
// No dependencies; included by quad_shape_preservation_matrix.sv, which checks its own logic.
`ifndef QUAD_SHAPE_PRESERVATION_MATRIX_ASSERT_SVH
`define QUAD_SHAPE_PRESERVATION_MATRIX_ASSERT_SVH

// same-cycle implication
`define QSPM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qspm: implication check failed");

// next-cycle implication
`define QSPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qspm: next-cycle check failed");

`endif

### rtl/core/qspm_pkg.sv
// Shared types and constants for the quad shape-preservation matrix block.
// No dependencies.
package qspm_pkg;

   localparam int LANES    = 8;
   localparam int ROWS     = 8;
   localparam int ROW_BITS = 3;
   localparam int COEF_BITS = 32;
   localparam int VERTS    = 4;

   // per-row tag that rides the divider pipeline
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic                degen;
      logic [LANES-1:0]    neg;
   } row_tag_type;

endpackage

### rtl/core/qspm_divider.sv
// Eight-lane pipelined restoring divider, one quotient bit per stage, rounded output.
// Depends on qspm_pkg.
module qspm_divider #(
   parameter int DEN_BITS = 39,
   parameter int QUO_BITS = 32
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                in_vld,
   input  qspm_pkg::row_tag_type                               in_tag,
   input  logic [DEN_BITS-1:0]                                 in_den,
   input  logic [qspm_pkg::LANES-1:0][DEN_BITS:0]              in_mag,
   output logic                                                out_vld,
   output qspm_pkg::row_tag_type                               out_tag,
   output logic [qspm_pkg::LANES-1:0][QUO_BITS-1:0]            out_quo
);

   localparam int RW = DEN_BITS + 1;

   logic [QUO_BITS-1:0]         vld_ff, vld_in;
   qspm_pkg::row_tag_type       tag_ff [QUO_BITS];
   qspm_pkg::row_tag_type       tag_in [QUO_BITS];
   logic [DEN_BITS-1:0]         den_ff [QUO_BITS];
   logic [DEN_BITS-1:0]         den_in [QUO_BITS];
   logic [RW-1:0]               rem_ff [QUO_BITS][qspm_pkg::LANES];
   logic [RW-1:0]               rem_in [QUO_BITS][qspm_pkg::LANES];
   logic [QUO_BITS-1:0]         q_ff   [QUO_BITS][qspm_pkg::LANES];
   logic [QUO_BITS-1:0]         q_in   [QUO_BITS][qspm_pkg::LANES];

   always_comb begin
      logic [RW-1:0]       trial;
      logic [QUO_BITS-1:0] prev_q;
      logic [DEN_BITS-1:0] den;
      for (int j = 0; j < QUO_BITS; j++) begin
         if (j == 0) begin
            vld_in[j] = in_vld;
            tag_in[j] = in_tag;
            den       = in_den;
         end else begin
            vld_in[j] = vld_ff[j-1];
            tag_in[j] = tag_ff[j-1];
            den       = den_ff[j-1];
         end
         den_in[j] = den;
         for (int l = 0; l < qspm_pkg::LANES; l++) begin
            if (j == 0) begin
               trial  = in_mag[l];
               prev_q = '0;
            end else begin
               trial  = {rem_ff[j-1][l][RW-2:0], 1'b0};
               prev_q = q_ff[j-1][l];
            end
            if (trial >= {1'b0, den}) begin
               rem_in[j][l] = trial - {1'b0, den};
               q_in[j][l]   = {prev_q[QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in[j][l] = trial;
               q_in[j][l]   = {prev_q[QUO_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   // round half up on the extra low quotient bit
   always_comb begin
      logic [QUO_BITS:0] sum;
      for (int l = 0; l < qspm_pkg::LANES; l++) begin
         sum        = {1'b0, q_ff[QUO_BITS-1][l]} + {{QUO_BITS{1'b0}}, 1'b1};
         out_quo[l] = sum[QUO_BITS:1];
      end
   end

   assign out_vld = vld_ff[QUO_BITS-1];
   assign out_tag = tag_ff[QUO_BITS-1];

endmodule

### rtl/core/quad_shape_preservation_matrix.sv
// Quad shape-preservation matrix: top level with front end, row sequencer and output stage.
// Depends on qspm_pkg, qspm_divider and quad_shape_preservation_matrix_assert.svh.
//
// One quad (four vertices, unsigned fixed point) is taken per start beat while busy is
// low; busy then stays high for the rest of the quad's eight row slots, and each quad
// gives eight row beats, one per cycle, on rsp_strobe. The row beats of a quad are
// contiguous, in order 0 to 7, with last_row on row 7. After the accepting edge a quad
// passes the front end, the row sequencer, the product and numerator registers, the
// 8-lane divider, which resolves one quotient bit per stage, and the output register.
// The result channel cannot be held off: a row beat is gone after its single cycle. The
// eight coefficients of a row are the row of A(AtA)^-1At - I, rounded to nearest at
// COEF_FRAC_BITS fraction bits and saturated to 32 bits. When all four vertices
// coincide the rows are -I with degenerate set.
`include "quad_shape_preservation_matrix_assert.svh"

module quad_shape_preservation_matrix #(
   parameter int COORD_BITS     = 16,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [COORD_BITS-1:0]         req_v0_x,
   input  logic [COORD_BITS-1:0]         req_v0_y,
   input  logic [COORD_BITS-1:0]         req_v1_x,
   input  logic [COORD_BITS-1:0]         req_v1_y,
   input  logic [COORD_BITS-1:0]         req_v2_x,
   input  logic [COORD_BITS-1:0]         req_v2_y,
   input  logic [COORD_BITS-1:0]         req_v3_x,
   input  logic [COORD_BITS-1:0]         req_v3_y,
   output logic                          rsp_strobe,
   output logic [qspm_pkg::ROW_BITS-1:0] rsp_row_index,
   output logic signed [31:0]            rsp_coef_0,
   output logic signed [31:0]            rsp_coef_1,
   output logic signed [31:0]            rsp_coef_2,
   output logic signed [31:0]            rsp_coef_3,
   output logic signed [31:0]            rsp_coef_4,
   output logic signed [31:0]            rsp_coef_5,
   output logic signed [31:0]            rsp_coef_6,
   output logic signed [31:0]            rsp_coef_7,
   output logic                          rsp_last_row,
   output logic                          rsp_degenerate
);

   localparam int VN  = qspm_pkg::VERTS;
   localparam int LN  = qspm_pkg::LANES;
   localparam int RB  = qspm_pkg::ROW_BITS;
   localparam int SUW = COORD_BITS + 2;          // sum of four coordinates
   localparam int UW  = COORD_BITS + 3;          // centred coordinate, signed
   localparam int PW  = 2 * UW;                  // product width
   localparam int DW  = PW + 1;                  // energy denominator width
   localparam int NW  = PW + 1;                  // numerator width, signed
   localparam int QW  = COEF_FRAC_BITS + 2;      // raw quotient bits
   localparam int CW  = COEF_FRAC_BITS + 4;
   localparam int XW  = (CW > 33) ? CW : 33;     // coefficient arithmetic width
   localparam logic signed [XW-1:0] ONE_VAL  = {{(XW-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
   localparam logic signed [XW-1:0] QTR_VAL  = ONE_VAL >>> 2;
   localparam logic signed [XW-1:0] SAT_MAX  = {{(XW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [XW-1:0] SAT_MIN  = {{(XW-31){1'b1}}, {31{1'b0}}};
   localparam logic [RB-1:0]        LAST_ROW = RB'(qspm_pkg::ROWS - 1);

   // ---------------------------------------------------------------- accept
   logic          accept;
   logic [RB-1:0] busy_cnt_ff, busy_cnt_in;

   assign accept = start && !busy;
   assign busy   = (busy_cnt_ff != '0);

   // hold busy for the rest of the quad's eight row slots
   always_comb begin
      busy_cnt_in = busy_cnt_ff;
      if (accept) begin
         busy_cnt_in = LAST_ROW;
      end else if (busy) begin
         busy_cnt_in = busy_cnt_ff - RB'(1);
      end
   end

   // ---------------------------------------------------------------- front end
   logic                         in_vld_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                         s5_vld_ff;
   logic [COORD_BITS-1:0]        x_ff [VN];
   logic [COORD_BITS-1:0]        y_ff [VN];
   logic signed [UW-1:0]         u_ff [VN];
   logic signed [UW-1:0]         v_ff [VN];
   logic signed [UW-1:0]         u_in [VN];
   logic signed [UW-1:0]         v_in [VN];
   logic [PW-1:0]                sq_ff [2*VN];
   logic [PW-1:0]                sq_in [2*VN];
   logic [DW-1:0]                pr_ff [VN];
   logic [DW-1:0]                pr_in [VN];
   logic [DW-1:0]                qs_ff [2];
   logic [DW-1:0]                den_ff, den_in;

   always_comb begin
      logic [SUW-1:0] sx;
      logic [SUW-1:0] sy;
      sx = '0;
      sy = '0;
      for (int k = 0; k < VN; k++) begin
         sx = sx + {2'b00, x_ff[k]};
         sy = sy + {2'b00, y_ff[k]};
      end
      for (int k = 0; k < VN; k++) begin
         u_in[k] = $signed({1'b0, x_ff[k], 2'b00}) - $signed({1'b0, sx});
         v_in[k] = $signed({1'b0, y_ff[k], 2'b00}) - $signed({1'b0, sy});
      end
   end

   always_comb begin
      logic signed [PW-1:0] sq;
      for (int k = 0; k < VN; k++) begin
         sq           = u_ff[k] * u_ff[k];
         sq_in[2*k]   = sq;
         sq           = v_ff[k] * v_ff[k];
         sq_in[2*k+1] = sq;
      end
      for (int k = 0; k < VN; k++) begin
         pr_in[k] = {1'b0, sq_ff[2*k]} + {1'b0, sq_ff[2*k+1]};
      end
      den_in = qs_ff[0] + qs_ff[1];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff[0] <= req_v0_x;
         y_ff[0] <= req_v0_y;
         x_ff[1] <= req_v1_x;
         y_ff[1] <= req_v1_y;
         x_ff[2] <= req_v2_x;
         y_ff[2] <= req_v2_y;
         x_ff[3] <= req_v3_x;
         y_ff[3] <= req_v3_y;
      end
      // centred coordinates hold until the next quad
      if (in_vld_ff) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
      sq_ff    <= sq_in;
      pr_ff    <= pr_in;
      qs_ff[0] <= pr_ff[0] + pr_ff[1];
      qs_ff[1] <= pr_ff[2] + pr_ff[3];
      den_ff   <= den_in;
   end

   // ---------------------------------------------------------------- row sequencer
   logic                  act_ff, act_in;
   logic [RB-1:0]         cnt_ff, cnt_in;
   logic signed [UW-1:0]  hu_ff [VN];
   logic signed [UW-1:0]  hv_ff [VN];
   logic [DW-1:0]         hden_ff;
   logic                  hdegen_ff;
   logic                  seq_load;

   assign seq_load = s5_vld_ff;

   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (seq_load) begin
         act_in = 1'b1;
         cnt_in = '0;
      end else if (act_ff) begin
         if (cnt_ff == LAST_ROW) begin
            act_in = 1'b0;
         end
         cnt_in = cnt_ff + RB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (seq_load) begin
         hu_ff     <= u_ff;
         hv_ff     <= v_ff;
         hden_ff   <= den_ff;
         hdegen_ff <= (den_ff == '0);
      end
   end

   // ---------------------------------------------------------------- products
   // Per lane c: same axis  -> a1*b1 + a2*b2 = u_k u_m + v_k v_m
   //             x row, y col -> u_k v_m - v_k u_m
   //             y row, x col -> v_k u_m - u_k v_m
   logic                  r1_vld_ff;
   logic [RB-1:0]         r1_row_ff;
   logic                  r1_degen_ff;
   logic [DW-1:0]         r1_den_ff;
   logic signed [PW-1:0]  p1_ff [LN];
   logic signed [PW-1:0]  p2_ff [LN];
   logic signed [PW-1:0]  p1_in [LN];
   logic signed [PW-1:0]  p2_in [LN];

   always_comb begin
      logic [1:0]           kr;
      logic [1:0]           m;
      logic [RB-1:0]        col;
      logic signed [UW-1:0] a1, b1, a2, b2;
      kr = cnt_ff[RB-1:1];
      for (int c = 0; c < LN; c++) begin
         col = RB'(c);
         m   = col[RB-1:1];
         if (cnt_ff[0] == col[0]) begin
            a1 = hu_ff[kr];
            b1 = hu_ff[m];
            a2 = hv_ff[kr];
            b2 = hv_ff[m];
         end else if (!cnt_ff[0]) begin
            a1 = hu_ff[kr];
            b1 = hv_ff[m];
            a2 = hv_ff[kr];
            b2 = hu_ff[m];
         end else begin
            a1 = hv_ff[kr];
            b1 = hu_ff[m];
            a2 = hu_ff[kr];
            b2 = hv_ff[m];
         end
         p1_in[c] = a1 * b1;
         p2_in[c] = a2 * b2;
      end
   end

   always_ff @(posedge clock) begin
      r1_row_ff   <= cnt_ff;
      r1_degen_ff <= hdegen_ff;
      r1_den_ff   <= hden_ff;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
   end

   // ---------------------------------------------------------------- numerators
   logic                                r2_vld_ff;
   qspm_pkg::row_tag_type               r2_tag_ff, r2_tag_in;
   logic [DW-1:0]                       r2_den_ff;
   logic [LN-1:0][DW:0]                 r2_mag_ff, r2_mag_in;

   always_comb begin
      logic signed [NW-1:0] num;
      logic [RB-1:0]        col;
      r2_tag_in.row   = r1_row_ff;
      r2_tag_in.degen = r1_degen_ff;
      for (int c = 0; c < LN; c++) begin
         col = RB'(c);
         if (r1_row_ff[0] == col[0]) begin
            num = NW'(p1_ff[c]) + NW'(p2_ff[c]);
         end else begin
            num = NW'(p1_ff[c]) - NW'(p2_ff[c]);
         end
         r2_tag_in.neg[c] = num[NW-1];
         r2_mag_in[c]     = num[NW-1] ? {1'b0, NW'(-num)} : {1'b0, num};
      end
   end

   always_ff @(posedge clock) begin
      r2_tag_ff <= r2_tag_in;
      r2_den_ff <= r1_den_ff;
      r2_mag_ff <= r2_mag_in;
   end

   // ---------------------------------------------------------------- divider
   logic                        dv_vld;
   qspm_pkg::row_tag_type       dv_tag;
   logic [LN-1:0][QW-1:0]       dv_quo;

   qspm_divider #(
      .DEN_BITS (DW),
      .QUO_BITS (QW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (r2_vld_ff),
      .in_tag  (r2_tag_ff),
      .in_den  (r2_den_ff),
      .in_mag  (r2_mag_ff),
      .out_vld (dv_vld),
      .out_tag (dv_tag),
      .out_quo (dv_quo)
   );

   // ---------------------------------------------------------------- output beat
   logic                 out_vld_ff;
   logic [RB-1:0]        out_row_ff;
   logic                 out_degen_ff;
   logic signed [31:0]   coef_ff [LN];
   logic signed [31:0]   coef_in [LN];

   // add the exact base, then saturate; coincident vertices give -I
   always_comb begin
      logic [RB-1:0]        col;
      logic                 diag;
      logic signed [XW-1:0] base;
      logic signed [XW-1:0] term;
      logic signed [XW-1:0] val;
      for (int c = 0; c < LN; c++) begin
         col  = RB'(c);
         diag = (col == dv_tag.row);
         term = $signed({{(XW-QW){1'b0}}, dv_quo[c]});
         if (col[0] == dv_tag.row[0]) begin
            base = diag ? (QTR_VAL - ONE_VAL) : QTR_VAL;
         end else begin
            base = '0;
         end
         if (dv_tag.degen) begin
            val = diag ? -ONE_VAL : '0;
         end else if (dv_tag.neg[c]) begin
            val = base - term;
         end else begin
            val = base + term;
         end
         if (val > SAT_MAX) begin
            coef_in[c] = 32'sh7FFF_FFFF;
         end else if (val < SAT_MIN) begin
            coef_in[c] = 32'sh8000_0000;
         end else begin
            coef_in[c] = val[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_row_ff   <= dv_tag.row;
      out_degen_ff <= dv_tag.degen;
      coef_ff      <= coef_in;
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cnt_ff <= '0;
         in_vld_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         s4_vld_ff   <= 1'b0;
         s5_vld_ff   <= 1'b0;
         act_ff      <= 1'b0;
         cnt_ff      <= '0;
         r1_vld_ff   <= 1'b0;
         r2_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         busy_cnt_ff <= busy_cnt_in;
         in_vld_ff   <= accept;
         s1_vld_ff   <= in_vld_ff;
         s2_vld_ff   <= s1_vld_ff;
         s3_vld_ff   <= s2_vld_ff;
         s4_vld_ff   <= s3_vld_ff;
         s5_vld_ff   <= s4_vld_ff;
         act_ff      <= act_in;
         cnt_ff      <= cnt_in;
         r1_vld_ff   <= act_ff;
         r2_vld_ff   <= r1_vld_ff;
         out_vld_ff  <= dv_vld;
      end
   end

   assign rsp_strobe     = out_vld_ff;
   assign rsp_row_index  = out_row_ff;
   assign rsp_last_row   = (out_row_ff == LAST_ROW);
   assign rsp_degenerate = out_degen_ff;
   assign rsp_coef_0     = coef_ff[0];
   assign rsp_coef_1     = coef_ff[1];
   assign rsp_coef_2     = coef_ff[2];
   assign rsp_coef_3     = coef_ff[3];
   assign rsp_coef_4     = coef_ff[4];
   assign rsp_coef_5     = coef_ff[5];
   assign rsp_coef_6     = coef_ff[6];
   assign rsp_coef_7     = coef_ff[7];

   // ---------------------------------------------------------------- checks
   // a new quad may load while the previous one issues its last row
   `QSPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy)
   `QSPM_ASSERT_IMPLY(a_load_when_idle, clock, reset, seq_load, !act_ff || cnt_ff == LAST_ROW)
   `QSPM_ASSERT_IMPLY(a_rows_contiguous, clock, reset, rsp_strobe && rsp_row_index != '0, $past(rsp_strobe) && rsp_row_index == $past(rsp_row_index) + RB'(1))
   `QSPM_ASSERT_IMPLY(a_degen_off_diag, clock, reset, rsp_strobe && rsp_degenerate && rsp_row_index == '0, rsp_coef_1 == '0)

endmodule
